[rtl/core/sdcid_pkg.sv]
package sdcid_pkg;

  // Card type codes
  localparam logic [2:0] MODE_MMC  = 3'd0;
  localparam logic [2:0] MODE_SDHC = 3'd3;

  // Status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_BAD_TYPE = 2'd1;
  localparam logic [1:0] STS_BAD_VSN  = 2'd2;
  localparam logic [1:0] STS_BAD_CSD  = 2'd3;

  // Result indexes, in emission order
  localparam logic [4:0] IDX_MID    = 5'd0;
  localparam logic [4:0] IDX_OEM    = 5'd1;
  localparam logic [4:0] IDX_PNM    = 5'd2;
  localparam logic [4:0] IDX_HRV    = 5'd3;
  localparam logic [4:0] IDX_FRV    = 5'd4;
  localparam logic [4:0] IDX_SERIAL = 5'd5;
  localparam logic [4:0] IDX_YEAR   = 5'd6;
  localparam logic [4:0] IDX_MONTH  = 5'd7;
  localparam logic [4:0] IDX_VSN    = 5'd8;
  localparam logic [4:0] IDX_CCC    = 5'd9;
  localparam logic [4:0] IDX_NSAC   = 5'd10;
  localparam logic [4:0] IDX_TAAC   = 5'd11;
  localparam logic [4:0] IDX_R2W    = 5'd12;
  localparam logic [4:0] IDX_RATE   = 5'd13;
  localparam logic [4:0] IDX_RD_BL  = 5'd14;
  localparam logic [4:0] IDX_WR_BL  = 5'd15;
  localparam logic [4:0] IDX_CAP    = 5'd16;
  localparam logic [4:0] IDX_FLAGS  = 5'd17;
  localparam logic [4:0] IDX_SECTOR = 5'd18;
  localparam logic [4:0] IDX_BYTES  = 5'd19;
  localparam logic [4:0] IDX_LAST   = IDX_BYTES;

  // Decoded register contents, each field at its natural width
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  mid;
    logic [15:0] oem;
    logic [55:0] pnm;      // name bytes, first byte at the top
    logic [3:0]  hrv;
    logic [3:0]  frv;
    logic [31:0] serial;
    logic [11:0] year;
    logic [3:0]  month;
    logic [3:0]  vsn;
    logic [11:0] ccc;
    logic [14:0] nsac;
    logic [26:0] taac;
    logic [2:0]  r2w;
    logic [29:0] rate;
    logic [3:0]  rd_bl;
    logic [3:0]  wr_bl;
    logic [32:0] cap;
    logic [3:0]  flags;
    logic [15:0] sector;
    logic [41:0] bytes;
  } dec_t;

  // Transfer and access time mantissa, scaled by ten
  function automatic logic [6:0] mant_x10(input logic [3:0] m);
    logic [6:0] r;
    case (m)
      4'd0:    r = 7'd0;
      4'd1:    r = 7'd10;
      4'd2:    r = 7'd12;
      4'd3:    r = 7'd13;
      4'd4:    r = 7'd15;
      4'd5:    r = 7'd20;
      4'd6:    r = 7'd25;
      4'd7:    r = 7'd30;
      4'd8:    r = 7'd35;
      4'd9:    r = 7'd40;
      4'd10:   r = 7'd45;
      4'd11:   r = 7'd50;
      4'd12:   r = 7'd55;
      4'd13:   r = 7'd60;
      4'd14:   r = 7'd70;
      default: r = 7'd80;
    endcase
    return r;
  endfunction

  // Maximum transfer rate in bit/s; exponents above three read as zero
  function automatic logic [29:0] rate_of(input logic [2:0] e, input logic [3:0] m);
    logic [29:0] mx;
    logic [29:0] r;
    mx = {23'd0, mant_x10(m)};
    case (e)
      3'd0:    r = mx * 30'd10000;
      3'd1:    r = mx * 30'd100000;
      3'd2:    r = mx * 30'd1000000;
      3'd3:    r = mx * 30'd10000000;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Access time in ns, rounded up: unit exponent takes the ceiling of mant/10
  function automatic logic [26:0] taac_of(input logic [2:0] e, input logic [3:0] m);
    logic [26:0] mx;
    logic [26:0] r;
    mx = {20'd0, mant_x10(m)};
    case (e)
      3'd0: begin
        case (m)
          4'd0:                      r = 27'd0;
          4'd1:                      r = 27'd1;
          4'd2, 4'd3, 4'd4, 4'd5:    r = 27'd2;
          4'd6, 4'd7:                r = 27'd3;
          4'd8, 4'd9:                r = 27'd4;
          4'd10, 4'd11:              r = 27'd5;
          4'd12, 4'd13:              r = 27'd6;
          4'd14:                     r = 27'd7;
          default:                   r = 27'd8;
        endcase
      end
      3'd1:    r = mx;
      3'd2:    r = mx * 27'd10;
      3'd3:    r = mx * 27'd100;
      3'd4:    r = mx * 27'd1000;
      3'd5:    r = mx * 27'd10000;
      3'd6:    r = mx * 27'd100000;
      default: r = mx * 27'd1000000;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/sdcid_decode.sv]
module sdcid_decode
  import sdcid_pkg::*;
(
  input  logic [2:0]   mode,
  input  logic [127:0] cid,
  input  logic [127:0] csd,
  output dec_t         dec
);

  logic [3:0]  vsn;
  logic [1:0]  structure;
  logic        is_sd2;
  logic [12:0] c_size1;
  logic [22:0] c_size2;
  logic [2:0]  c_mult;
  logic [3:0]  rd_bl;

  assign vsn       = csd[125:122];
  assign structure = csd[127:126];
  assign is_sd2    = (mode != MODE_MMC) && (structure == 2'd1);
  assign c_size1   = {1'b0, csd[73:62]} + 13'd1;
  assign c_size2   = {1'b0, csd[69:48]} + 23'd1;
  assign c_mult    = csd[49:47];
  assign rd_bl     = csd[83:80];

  // Decode CID by card family, then CSD by structure
  always_comb begin
    dec        = '0;
    dec.status = STS_OK;
    dec.mid    = cid[127:120];
    dec.oem    = cid[119:104];
    dec.pnm    = cid[103:48];

    if (mode == MODE_MMC) begin
      dec.vsn   = vsn;
      dec.year  = {8'd0, cid[11:8]} + 12'd1997;
      dec.month = cid[15:12];
      if (vsn <= 4'd1) begin
        dec.hrv    = cid[47:44];
        dec.frv    = cid[43:40];
        dec.serial = {8'd0, cid[39:16]};
      end else begin
        dec.serial = cid[47:16];
        dec.pnm    = {cid[103:56], 8'd0};
      end
    end else begin
      dec.hrv    = cid[63:60];
      dec.frv    = cid[59:56];
      dec.serial = cid[55:24];
      dec.year   = {4'd0, cid[19:12]} + 12'd2000;
      dec.month  = cid[11:8];
      dec.pnm    = {cid[103:64], 16'd0};
    end

    dec.ccc  = csd[95:84];
    dec.rate = rate_of(csd[98:96], csd[102:99]);

    if (is_sd2) begin
      dec.r2w    = 3'd4;
      dec.rd_bl  = 4'd9;
      dec.wr_bl  = 4'd9;
      dec.cap    = {c_size2, 10'd0};
      dec.sector = 16'd512;
      dec.bytes  = {c_size2, 19'd0};
    end else begin
      dec.nsac   = {7'd0, csd[111:104]} * 15'd100;
      dec.taac   = taac_of(csd[114:112], csd[118:115]);
      dec.r2w    = csd[28:26];
      dec.rd_bl  = rd_bl;
      dec.wr_bl  = csd[25:22];
      dec.cap    = {20'd0, c_size1} << ({1'b0, c_mult} + 4'd2);
      dec.flags  = {csd[21], csd[78], csd[77], csd[79]};
      dec.sector = 16'd1 << rd_bl;
      dec.bytes  = {29'd0, c_size1} << ({2'd0, c_mult} + 5'd2 + {1'b0, rd_bl});
    end

    // Rejections, in priority order
    if (mode > MODE_SDHC) begin
      dec.status = STS_BAD_TYPE;
    end else if (mode == MODE_MMC && vsn > 4'd4) begin
      dec.status = STS_BAD_VSN;
    end else if (mode == MODE_MMC && structure != 2'd1 && structure != 2'd2) begin
      dec.status = STS_BAD_CSD;
    end else if (mode != MODE_MMC && structure > 2'd1) begin
      dec.status = STS_BAD_CSD;
    end
  end

endmodule

[rtl/core/sdcid_serial.sv]
module sdcid_serial
  import sdcid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  dec_t        dec,
  output logic        free,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,
  output logic [6:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  dec_t       bank;
  logic       busy;
  logic [4:0] count;
  logic       last;
  logic       err;

  assign err  = (bank.status != STS_OK);
  assign last = err || (count == IDX_LAST);
  assign free = !busy || (m_axis_tready && last);

  // Hold the decoded set and step through it one transaction a cycle while m_axis_tready is high
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= IDX_MID;
    end else if (load) begin
      busy  <= 1'b1;
      count <= IDX_MID;
    end else if (busy && m_axis_tready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        count <= count + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bank <= dec;
    end
  end

  // Select the field for the current index; a rejected set gives zero
  always_comb begin
    case (count)
      IDX_MID:    m_axis_tdata = 64'(bank.mid);
      IDX_OEM:    m_axis_tdata = 64'(bank.oem);
      IDX_PNM:    m_axis_tdata = {bank.pnm, 8'd0};
      IDX_HRV:    m_axis_tdata = 64'(bank.hrv);
      IDX_FRV:    m_axis_tdata = 64'(bank.frv);
      IDX_SERIAL: m_axis_tdata = 64'(bank.serial);
      IDX_YEAR:   m_axis_tdata = 64'(bank.year);
      IDX_MONTH:  m_axis_tdata = 64'(bank.month);
      IDX_VSN:    m_axis_tdata = 64'(bank.vsn);
      IDX_CCC:    m_axis_tdata = 64'(bank.ccc);
      IDX_NSAC:   m_axis_tdata = 64'(bank.nsac);
      IDX_TAAC:   m_axis_tdata = 64'(bank.taac);
      IDX_R2W:    m_axis_tdata = 64'(bank.r2w);
      IDX_RATE:   m_axis_tdata = 64'(bank.rate);
      IDX_RD_BL:  m_axis_tdata = 64'(bank.rd_bl);
      IDX_WR_BL:  m_axis_tdata = 64'(bank.wr_bl);
      IDX_CAP:    m_axis_tdata = 64'(bank.cap);
      IDX_FLAGS:  m_axis_tdata = 64'(bank.flags);
      IDX_SECTOR: m_axis_tdata = 64'(bank.sector);
      IDX_BYTES:  m_axis_tdata = 64'(bank.bytes);
      default:    m_axis_tdata = 64'd0;
    endcase
    if (err) begin
      m_axis_tdata = 64'd0;
    end
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tuser  = {bank.status, count};
  assign m_axis_tlast  = last;

endmodule

[rtl/core/sd_mmc_cid_csd_decoder_unit.sv]
// SD / MMC CID and CSD decoder.
// Slave side: one transaction carries a card type and the raw CID and CSD
// registers. Master side: each input yields twenty indexed results in fixed
// order (index in tuser), tlast on the final one; a rejected input yields a
// single result with index 0, value 0, the error code in tuser and tlast set.
// Path: the input is registered, then decoded combinationally and loaded
// into the result bank once the serialiser is free; m_axis_tvalid rises
// as the bank is loaded.
// Throughput: one result per cycle while the receiver is ready; the result
// serialiser is the limiting unit. The next input is taken into the input
// register while the current results are still being delivered, and moves
// into the bank as the last result leaves; a new input is accepted in that
// same cycle.
// Stalls: a low m_axis_tready holds the current result stable; once the input
// register is full and the bank cannot take it, s_axis_tready drops.
// Reset: rst (synchronous, active high) drops all pending work; both sides
// come up empty with s_axis_tready high.
module sd_mmc_cid_csd_decoder_unit
  import sdcid_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode[2:0], cid_high[66:3], cid_low[130:67], csd_high[194:131],
  // csd_low[258:195], zero pad[263:259]
  input  logic [263:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // item_value[63:0]
  output logic [63:0]  m_axis_tdata,
  // item_index[4:0], status[6:5]
  output logic [6:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  logic         in_valid;
  logic [2:0]   in_mode;
  logic [127:0] in_cid;
  logic [127:0] in_csd;
  logic         free;
  logic         load;
  dec_t         dec;

  assign s_axis_tready = !in_valid || free;
  assign load          = in_valid && free;

  // Capture an input transaction; release it once the bank takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode <= s_axis_tdata[2:0];
      in_cid  <= {s_axis_tdata[66:3], s_axis_tdata[130:67]};
      in_csd  <= {s_axis_tdata[194:131], s_axis_tdata[258:195]};
    end
  end

  sdcid_decode u_decode (
    .mode (in_mode),
    .cid  (in_cid),
    .csd  (in_csd),
    .dec  (dec)
  );

  sdcid_serial u_serial (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .dec           (dec),
    .free          (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
